@@ rtl/trlf_pkg.sv @@
`default_nettype none

package trlf_pkg;

  // field widths
  localparam int AMT_W = 51;
  localparam int SUM_W = 64;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_ADD_CLEAN = 2'd0,
    OP_ADD_TAINT = 2'd1,
    OP_ASSIGN    = 2'd2,
    OP_QUERY     = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVER = 2'd1,
    ST_FULL = 2'd2
  } st_t;

  // run memory read selection
  typedef enum logic [2:0] {
    RD_NONE = 3'd0,
    RD_LAST = 3'd1,
    RD_PREV = 3'd2,
    RD_WALK = 3'd3,
    RD_EMIT = 3'd4
  } rd_sel_t;

  // add step actions
  typedef enum logic [2:0] {
    ADD_NONE = 3'd0,
    ADD_EXT  = 3'd1,
    ADD_MRG  = 3'd2,
    ADD_PUSH = 3'd3,
    ADD_ZERO = 3'd4,
    ADD_FULL = 3'd5
  } add_t;

  // result register load selection
  typedef enum logic [1:0] {
    EMIT_NONE  = 2'd0,
    EMIT_RESP  = 2'd1,
    EMIT_RUN   = 2'd2,
    EMIT_SPLIT = 2'd3
  } emit_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;
    rd_sel_t rd;
    add_t    add;
    logic    err_over;
    logic    walk_take;
    logic    walk_stop;
    logic    fin1;
    logic    fin2;
    logic    fin3;
    emit_t   emit;
    logic    commit;
    logic    push_zero;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_t  op;
    logic cnt_zero;
    logic cnt_odd;
    logic cnt_one;
    logic cnt_full;
    logic rd_zero;
    logic over;
    logic walk_end;
    logic fits;
    logic taken_nz;
    logic taken_odd;
    logic split;
    logic k_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/taint_run_length_fifo.sv @@
`default_nettype none

// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_operation, in_amount
// out      output     out_valid / out_ready  out_status, out_seg_*, out_last,
//                                            out_taint_total, out_grand_total,
//                                            out_has_taint
//
// one item at a time; an assign reads the runs it takes one by one, emits each whole
// run taken and then the split run, if any; an assign over the stored total only
// returns a status result; the walk and emit order is set by the single
// registered read port of the run memory
// rst_n is synchronous; it empties the ring and clears the sums, no clearing pass
// a stalled result holds the sequencer; the next item is taken only after the
// previous one has loaded its last result into the output register and updated the ring

module taint_run_length_fifo #(
  parameter int DEPTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_operation,
  input  wire logic [trlf_pkg::AMT_W-1:0] in_amount,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      out_status,
  output logic                            out_seg_valid,
  output logic [trlf_pkg::SUM_W-1:0]      out_seg_value,
  output logic                            out_seg_is_taint,
  output logic                            out_last,
  output logic [trlf_pkg::SUM_W-1:0]      out_taint_total,
  output logic [trlf_pkg::SUM_W-1:0]      out_grand_total,
  output logic                            out_has_taint
);

  trlf_pkg::dp_cmd_t cmd;
  trlf_pkg::dp_sts_t sts;

  // sequencer
  trlf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // ring, sums and result register
  trlf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_operation     (in_operation),
    .in_amount        (in_amount),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_seg_valid    (out_seg_valid),
    .out_seg_value    (out_seg_value),
    .out_seg_is_taint (out_seg_is_taint),
    .out_last         (out_last),
    .out_taint_total  (out_taint_total),
    .out_grand_total  (out_grand_total),
    .out_has_taint    (out_has_taint)
  );

endmodule

`default_nettype wire

@@ rtl/trlf_ctrl.sv @@
`default_nettype none

module trlf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire trlf_pkg::dp_sts_t sts,
  output trlf_pkg::dp_cmd_t      cmd
);

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_DISP     = 17'h00002,
    S_ADD_CHK  = 17'h00004,
    S_ADD_MRG  = 17'h00008,
    S_ADD_PSH2 = 17'h00010,
    S_RESP     = 17'h00020,
    S_W_RD     = 17'h00040,
    S_W_CHK    = 17'h00080,
    S_FIN1     = 17'h00100,
    S_FIN2     = 17'h00200,
    S_FIN3     = 17'h00400,
    S_EM_RD    = 17'h00800,
    S_EM_OUT   = 17'h01000,
    S_EM_SPLIT = 17'h02000,
    S_COMMIT   = 17'h04000,
    S_ASG_ZERO = 17'h08000,
    S_SPARE    = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencing and command decode
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.rd        = trlf_pkg::RD_NONE;
    cmd.add       = trlf_pkg::ADD_NONE;
    cmd.err_over  = 1'b0;
    cmd.walk_take = 1'b0;
    cmd.walk_stop = 1'b0;
    cmd.fin1      = 1'b0;
    cmd.fin2      = 1'b0;
    cmd.fin3      = 1'b0;
    cmd.emit      = trlf_pkg::EMIT_NONE;
    cmd.commit    = 1'b0;
    cmd.push_zero = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          trlf_pkg::OP_QUERY: begin
            state_nxt = S_RESP;
          end
          trlf_pkg::OP_ASSIGN: begin
            if (sts.over) begin
              cmd.err_over = 1'b1;
              state_nxt    = S_RESP;
            end else begin
              state_nxt = S_W_RD;
            end
          end
          default: begin
            // fetch the last run for either add when the ring is not empty
            if (!sts.cnt_zero) begin
              cmd.rd = trlf_pkg::RD_LAST;
            end
            state_nxt = S_ADD_CHK;
          end
        endcase
      end
      S_ADD_CHK: begin
        state_nxt = S_RESP;
        if (sts.op == trlf_pkg::OP_ADD_CLEAN) begin
          if (sts.cnt_odd) begin
            cmd.add = trlf_pkg::ADD_EXT;
          end else if (sts.cnt_zero) begin
            cmd.add = trlf_pkg::ADD_PUSH;
          end else if (sts.rd_zero) begin
            cmd.rd    = trlf_pkg::RD_PREV;
            state_nxt = S_ADD_MRG;
          end else if (sts.cnt_full) begin
            cmd.add = trlf_pkg::ADD_FULL;
          end else begin
            cmd.add = trlf_pkg::ADD_PUSH;
          end
        end else begin
          if (sts.cnt_odd) begin
            if (!sts.cnt_one && sts.rd_zero) begin
              cmd.rd    = trlf_pkg::RD_PREV;
              state_nxt = S_ADD_MRG;
            end else if (sts.cnt_full) begin
              cmd.add = trlf_pkg::ADD_FULL;
            end else begin
              cmd.add = trlf_pkg::ADD_PUSH;
            end
          end else if (sts.cnt_zero) begin
            // empty ring: leading zero clean run first
            cmd.add   = trlf_pkg::ADD_ZERO;
            state_nxt = S_ADD_PSH2;
          end else begin
            cmd.add = trlf_pkg::ADD_EXT;
          end
        end
      end
      S_ADD_MRG: begin
        cmd.add   = trlf_pkg::ADD_MRG;
        state_nxt = S_RESP;
      end
      S_ADD_PSH2: begin
        cmd.add   = trlf_pkg::ADD_PUSH;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit  = trlf_pkg::EMIT_RESP;
          state_nxt = S_IDLE;
        end
      end
      S_W_RD: begin
        if (sts.walk_end) begin
          state_nxt = S_FIN1;
        end else begin
          cmd.rd    = trlf_pkg::RD_WALK;
          state_nxt = S_W_CHK;
        end
      end
      S_W_CHK: begin
        if (sts.fits) begin
          cmd.walk_take = 1'b1;
          state_nxt     = S_W_RD;
        end else begin
          cmd.walk_stop = 1'b1;
          state_nxt     = S_FIN1;
        end
      end
      S_FIN1: begin
        cmd.fin1  = 1'b1;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        cmd.fin2  = 1'b1;
        state_nxt = S_FIN3;
      end
      S_FIN3: begin
        cmd.fin3 = 1'b1;
        if (sts.taken_nz) begin
          state_nxt = S_EM_RD;
        end else if (sts.split) begin
          state_nxt = S_EM_SPLIT;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_EM_RD: begin
        cmd.rd    = trlf_pkg::RD_EMIT;
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (sts.out_free) begin
          cmd.emit = trlf_pkg::EMIT_RUN;
          if (!sts.k_last) begin
            state_nxt = S_EM_RD;
          end else if (sts.split) begin
            state_nxt = S_EM_SPLIT;
          end else begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_EM_SPLIT: begin
        if (sts.out_free) begin
          cmd.emit  = trlf_pkg::EMIT_SPLIT;
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = sts.taken_odd ? S_ASG_ZERO : S_IDLE;
      end
      S_ASG_ZERO: begin
        cmd.push_zero = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/trlf_dp.sv @@
`default_nettype none

module trlf_dp #(
  parameter int DEPTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [1:0]                    in_operation,
  input  wire logic [trlf_pkg::AMT_W-1:0]    in_amount,
  input  wire trlf_pkg::dp_cmd_t             cmd,
  output trlf_pkg::dp_sts_t                  sts,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic                               out_seg_valid,
  output logic [trlf_pkg::SUM_W-1:0]         out_seg_value,
  output logic                               out_seg_is_taint,
  output logic                               out_last,
  output logic [trlf_pkg::SUM_W-1:0]         out_taint_total,
  output logic [trlf_pkg::SUM_W-1:0]         out_grand_total,
  output logic                               out_has_taint
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int VW = trlf_pkg::SUM_W;

  // ring slot of a position counted from the head
  function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
                                              input logic [CW-1:0] ofs);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(ofs);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [VW-1:0] mem [DEPTH];
  logic [VW-1:0] rd_data_r;

  logic [AW-1:0] head_r;
  logic [CW-1:0] count_r, nzt_r;
  logic [VW-1:0] tsum_r, gsum_r;

  trlf_pkg::op_t op_r;
  trlf_pkg::st_t status_r;
  logic [VW-1:0] amt_r, got_r, tsub_r, front_r, diff_r;
  logic [CW-1:0] idx_r, k_r, nzdec_r;
  logic          front_v_r, split_r;

  logic          out_valid_r;
  trlf_pkg::st_t out_status_r;
  logic          out_seg_valid_r, out_seg_is_taint_r, out_last_r, out_has_taint_r;
  logic [VW-1:0] out_seg_value_r, out_taint_total_r, out_grand_total_r;

  logic [CW-1:0] cnt_m1, cnt_m2;
  logic [AW-1:0] head_dec;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [VW-1:0] wr_data;
  logic [VW-1:0] add_base, add_sum;
  logic          taint_op;
  logic [CW-1:0] add_nzt;
  logic [VW-1:0] got_nxt, front_nxt;
  logic          odd_split;
  logic [CW-1:0] fin_nzt;
  logic          k_last;

  assign cnt_m1   = count_r - CW'(1);
  assign cnt_m2   = count_r - CW'(2);
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);

  // add arithmetic
  assign add_base = (cmd.add == trlf_pkg::ADD_PUSH) ? '0 : rd_data_r;
  assign add_sum  = add_base + amt_r;
  assign taint_op = (op_r == trlf_pkg::OP_ADD_TAINT);
  assign add_nzt  = nzt_r + CW'(taint_op && (add_sum != '0))
                          - CW'(taint_op && (add_base != '0));

  // assign arithmetic
  assign got_nxt   = got_r + rd_data_r;
  assign front_nxt = front_r - diff_r;
  assign odd_split = split_r && idx_r[0];
  assign fin_nzt   = nzt_r - nzdec_r + CW'(odd_split && (front_nxt != '0))
                                     - CW'(odd_split && (front_r != '0));
  assign k_last    = ((k_r + CW'(1)) == idx_r);

  // read port address
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = ring_slot(head_r, idx_r);
    case (cmd.rd)
      trlf_pkg::RD_LAST: rd_addr = ring_slot(head_r, cnt_m1);
      trlf_pkg::RD_PREV: rd_addr = ring_slot(head_r, cnt_m2);
      trlf_pkg::RD_WALK: rd_addr = ring_slot(head_r, idx_r);
      trlf_pkg::RD_EMIT: rd_addr = ring_slot(head_r, k_r);
      default:           rd_en   = 1'b0;
    endcase
  end

  // write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ring_slot(head_r, count_r);
    wr_data = add_sum;
    case (cmd.add)
      trlf_pkg::ADD_EXT: begin
        wr_en   = 1'b1;
        wr_addr = ring_slot(head_r, cnt_m1);
      end
      trlf_pkg::ADD_MRG: begin
        wr_en   = 1'b1;
        wr_addr = ring_slot(head_r, cnt_m2);
      end
      trlf_pkg::ADD_PUSH: begin
        wr_en = 1'b1;
      end
      trlf_pkg::ADD_ZERO: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
    if (cmd.commit && split_r) begin
      wr_en   = 1'b1;
      wr_addr = ring_slot(head_r, idx_r);
      wr_data = front_r;
    end
    if (cmd.push_zero) begin
      wr_en   = 1'b1;
      wr_addr = head_dec;
      wr_data = '0;
    end
  end

  // run memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // ring pointers, sums and nonzero taint run count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      nzt_r   <= '0;
      tsum_r  <= '0;
      gsum_r  <= '0;
    end else begin
      case (cmd.add)
        trlf_pkg::ADD_EXT, trlf_pkg::ADD_MRG, trlf_pkg::ADD_PUSH: begin
          gsum_r <= gsum_r + amt_r;
          if (taint_op) begin
            tsum_r <= tsum_r + amt_r;
          end
          nzt_r <= add_nzt;
          if (cmd.add == trlf_pkg::ADD_PUSH) begin
            count_r <= count_r + CW'(1);
          end
        end
        trlf_pkg::ADD_ZERO: begin
          count_r <= count_r + CW'(1);
        end
        default: begin
        end
      endcase
      if (cmd.fin1) begin
        gsum_r <= gsum_r - amt_r;
      end
      if (cmd.fin2) begin
        nzt_r <= fin_nzt;
      end
      if (cmd.fin3) begin
        tsum_r <= tsum_r - tsub_r;
      end
      if (cmd.commit) begin
        head_r  <= ring_slot(head_r, idx_r);
        count_r <= count_r - idx_r;
      end
      if (cmd.push_zero) begin
        head_r  <= head_dec;
        count_r <= count_r + CW'(1);
      end
    end
  end

  // item registers and assign walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= trlf_pkg::op_t'(in_operation);
      amt_r     <= VW'(in_amount);
      status_r  <= trlf_pkg::ST_OK;
      idx_r     <= '0;
      k_r       <= '0;
      got_r     <= '0;
      tsub_r    <= '0;
      nzdec_r   <= '0;
      front_v_r <= 1'b0;
    end
    if (cmd.add == trlf_pkg::ADD_FULL) begin
      status_r <= trlf_pkg::ST_FULL;
    end
    if (cmd.err_over) begin
      status_r <= trlf_pkg::ST_OVER;
    end
    if (cmd.walk_take) begin
      got_r <= got_nxt;
      if (idx_r[0]) begin
        tsub_r <= tsub_r + rd_data_r;
      end
      nzdec_r <= nzdec_r + CW'(idx_r[0] && (rd_data_r != '0));
      idx_r   <= idx_r + CW'(1);
    end
    if (cmd.walk_stop) begin
      front_r   <= rd_data_r;
      front_v_r <= 1'b1;
    end
    if (cmd.fin1) begin
      diff_r  <= amt_r - got_r;
      split_r <= (amt_r != got_r) && front_v_r;
    end
    if (cmd.fin2) begin
      if (odd_split) begin
        tsub_r <= tsub_r + diff_r;
      end
      front_r <= front_nxt;
    end
    if (cmd.emit == trlf_pkg::EMIT_RUN) begin
      k_r <= k_r + CW'(1);
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit != trlf_pkg::EMIT_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.emit != trlf_pkg::EMIT_NONE) begin
      out_taint_total_r <= tsum_r;
      out_grand_total_r <= gsum_r;
      out_has_taint_r   <= (nzt_r != '0);
    end
    case (cmd.emit)
      trlf_pkg::EMIT_RESP: begin
        out_status_r       <= status_r;
        out_seg_valid_r    <= 1'b0;
        out_seg_value_r    <= '0;
        out_seg_is_taint_r <= 1'b0;
        out_last_r         <= 1'b1;
      end
      trlf_pkg::EMIT_RUN: begin
        out_status_r       <= trlf_pkg::ST_OK;
        out_seg_valid_r    <= 1'b1;
        out_seg_value_r    <= rd_data_r;
        out_seg_is_taint_r <= k_r[0];
        out_last_r         <= k_last && !split_r;
      end
      trlf_pkg::EMIT_SPLIT: begin
        out_status_r       <= trlf_pkg::ST_OK;
        out_seg_valid_r    <= 1'b1;
        out_seg_value_r    <= diff_r;
        out_seg_is_taint_r <= idx_r[0];
        out_last_r         <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // status to controller
  always_comb begin
    sts.op        = op_r;
    sts.cnt_zero  = (count_r == '0);
    sts.cnt_odd   = count_r[0];
    sts.cnt_one   = (count_r == CW'(1));
    sts.cnt_full  = (count_r == CW'(DEPTH));
    sts.rd_zero   = (rd_data_r == '0);
    sts.over      = (amt_r > gsum_r);
    sts.walk_end  = (idx_r == count_r);
    sts.fits      = (got_nxt <= amt_r);
    sts.taken_nz  = (idx_r != '0);
    sts.taken_odd = idx_r[0];
    sts.split     = split_r;
    sts.k_last    = k_last;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_seg_valid    = out_seg_valid_r;
  assign out_seg_value    = out_seg_value_r;
  assign out_seg_is_taint = out_seg_is_taint_r;
  assign out_last         = out_last_r;
  assign out_taint_total  = out_taint_total_r;
  assign out_grand_total  = out_grand_total_r;
  assign out_has_taint    = out_has_taint_r;

endmodule

`default_nettype wire

@@ verif/trlf_run_checker.sv @@
`default_nettype none

module trlf_run_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_ready,
  input  wire logic [1:0]                 in_operation,
  input  wire logic [trlf_pkg::AMT_W-1:0] in_amount,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire logic [1:0]                 out_status,
  input  wire logic                       out_seg_valid,
  input  wire logic [trlf_pkg::SUM_W-1:0] out_seg_value,
  input  wire logic                       out_seg_is_taint,
  input  wire logic                       out_last,
  input  wire logic [trlf_pkg::SUM_W-1:0] out_taint_total,
  input  wire logic [trlf_pkg::SUM_W-1:0] out_grand_total,
  input  wire logic                       out_has_taint,
  output int                              fail_count,
  output int                              pending,
  output logic [trlf_pkg::SUM_W-1:0]      stored_total
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING  = 32;
  localparam int AMT_W = trlf_pkg::AMT_W;
  localparam int SUM_W = trlf_pkg::SUM_W;

  typedef struct packed {
    trlf_pkg::st_t    status;
    logic             seg_valid;
    logic [SUM_W-1:0] seg_value;
    logic             seg_is_taint;
    logic             last;
    logic [SUM_W-1:0] taint_total;
    logic [SUM_W-1:0] grand_total;
    logic             has_taint;
  } run_result_t;

  // shadow copy of the run ring and the running sums
  logic [SUM_W-1:0] runs [RING];
  logic [4:0]       head;
  int               cnt;
  logic [SUM_W-1:0] taint_acc;
  logic [SUM_W-1:0] total_acc;

  run_result_t due_results [$];
  int          err_count = 0;

  function automatic logic [4:0] pos(int i);
    return 5'(int'(head) + i);
  endfunction

  function automatic void clear_ring();
    head      = '0;
    cnt       = 0;
    taint_acc = '0;
    total_acc = '0;
  endfunction

  // any nonzero tainted run still stored
  function automatic logic ring_has_taint();
    for (int i = 1; i < cnt; i += 2) begin
      if (runs[pos(i)] != '0) return 1'b1;
    end
    return 1'b0;
  endfunction

  // apply one item to the shadow ring and queue the results it causes
  function automatic void step_ring(trlf_pkg::op_t op, logic [AMT_W-1:0] amt);
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] got;
    logic [SUM_W-1:0] diff;
    logic [SUM_W-1:0] tsub;
    logic [SUM_W-1:0] v;
    logic [SUM_W-1:0] segs [$];
    trlf_pkg::st_t    st;
    int               ntake;
    logic             ht;
    run_result_t      r;
    a  = SUM_W'(amt);
    st = trlf_pkg::ST_OK;
    case (op)
      trlf_pkg::OP_ADD_CLEAN: begin
        if (cnt % 2 == 1) begin
          runs[pos(cnt - 1)] += a;
        end else if (cnt == 0) begin
          runs[pos(0)] = a;
          cnt = 1;
        end else if (runs[pos(cnt - 1)] == '0) begin
          // zero taint run at the back: fold into the clean run before it
          runs[pos(cnt - 2)] += a;
        end else if (cnt == RING) begin
          st = trlf_pkg::ST_FULL;
        end else begin
          runs[pos(cnt)] = a;
          cnt++;
        end
        if (st == trlf_pkg::ST_OK) total_acc += a;
      end
      trlf_pkg::OP_ADD_TAINT: begin
        if (cnt % 2 == 1) begin
          if (cnt >= 2 && runs[pos(cnt - 1)] == '0) begin
            runs[pos(cnt - 2)] += a;
          end else if (cnt == RING) begin
            st = trlf_pkg::ST_FULL;
          end else begin
            runs[pos(cnt)] = a;
            cnt++;
          end
        end else if (cnt == 0) begin
          // empty ring: zero clean run then the taint run
          runs[pos(0)] = '0;
          runs[pos(1)] = a;
          cnt = 2;
        end else begin
          runs[pos(cnt - 1)] += a;
        end
        if (st == trlf_pkg::ST_OK) begin
          taint_acc += a;
          total_acc += a;
        end
      end
      trlf_pkg::OP_ASSIGN: begin
        if (a > total_acc) begin
          st = trlf_pkg::ST_OVER;
        end else begin
          got   = '0;
          tsub  = '0;
          ntake = 0;
          // take whole runs off the front while they fit
          while (ntake < cnt) begin
            v = runs[pos(ntake)];
            if (got + v > a) break;
            got += v;
            segs.insert(segs.size(), v);
            if (ntake % 2 == 1) tsub += v;
            ntake++;
          end
          head = head + 5'(ntake);
          cnt  = cnt - ntake;
          diff = a - got;
          // split the front run at the cut
          if (diff != '0 && cnt > 0) begin
            runs[pos(0)] -= diff;
            segs.insert(segs.size(), diff);
            if (ntake % 2 == 1) tsub += diff;
          end
          // odd take: leading zero run keeps the parity
          if (ntake % 2 == 1) begin
            head = head - 5'd1;
            cnt++;
            runs[pos(0)] = '0;
          end
          total_acc -= a;
          taint_acc -= tsub;
        end
      end
      default: ;
    endcase

    ht = ring_has_taint();
    r.status      = st;
    r.taint_total = taint_acc;
    r.grand_total = total_acc;
    r.has_taint   = ht;
    if (segs.size() == 0) begin
      r.seg_valid    = 1'b0;
      r.seg_value    = '0;
      r.seg_is_taint = 1'b0;
      r.last         = 1'b1;
      due_results.insert(due_results.size(), r);
    end else begin
      for (int k = 0; k < segs.size(); k++) begin
        r.status       = trlf_pkg::ST_OK;
        r.seg_valid    = 1'b1;
        r.seg_value    = segs[k];
        r.seg_is_taint = (k % 2 == 1);
        r.last         = (k + 1 == segs.size());
        due_results.insert(due_results.size(), r);
      end
    end
  endfunction

  task automatic check_field(string name, logic [SUM_W-1:0] want, logic [SUM_W-1:0] seen);
    if (seen !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
    end
  endtask

  // compare each result item with the oldest prediction, then predict new items
  always @(posedge clk) begin
    run_result_t want;
    if (!rst_n) begin
      clear_ring();
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, actual status %0d seg %0h last %0b",
                   $time, out_status, out_seg_value, out_last);
        end else begin
          want = due_results.pop_front();
          check_field("status", SUM_W'(want.status), SUM_W'(out_status));
          check_field("seg_valid", SUM_W'(want.seg_valid), SUM_W'(out_seg_valid));
          check_field("seg_value", want.seg_value, out_seg_value);
          check_field("seg_is_taint", SUM_W'(want.seg_is_taint), SUM_W'(out_seg_is_taint));
          check_field("last", SUM_W'(want.last), SUM_W'(out_last));
          check_field("taint_total", want.taint_total, out_taint_total);
          check_field("grand_total", want.grand_total, out_grand_total);
          check_field("has_taint", SUM_W'(want.has_taint), SUM_W'(out_has_taint));
        end
      end
      if (in_valid && in_ready) step_ring(trlf_pkg::op_t'(in_operation), in_amount);
    end
    fail_count   <= err_count;
    pending      <= due_results.size();
    stored_total <= total_acc;
  end

endmodule

`default_nettype wire

@@ verif/taint_run_length_fifo_tb.sv @@
`default_nettype none

module taint_run_length_fifo_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int               AMT_W       = trlf_pkg::AMT_W;
  localparam int               SUM_W       = trlf_pkg::SUM_W;
  localparam int               N_RANDOM    = 150;
  localparam int               N_CALM      = 40;
  localparam int               FILL_LEN    = 34;
  localparam int               STALL_LIMIT = 4000;
  localparam int               TAIL        = 200;
  localparam logic [AMT_W-1:0] AMT_MAX     = '1;

  logic             clk;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_ready;
  logic [1:0]       in_operation = '0;
  logic [AMT_W-1:0] in_amount    = '0;
  logic             out_valid;
  logic             out_ready    = 1'b0;
  logic [1:0]       out_status;
  logic             out_seg_valid;
  logic [SUM_W-1:0] out_seg_value;
  logic             out_seg_is_taint;
  logic             out_last;
  logic [SUM_W-1:0] out_taint_total;
  logic [SUM_W-1:0] out_grand_total;
  logic             out_has_taint;

  logic             calm = 1'b0;
  int               fail_count;
  int               pending;
  logic [SUM_W-1:0] stored_total;
  int               idle_cycles = 0;

  taint_run_length_fifo uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_amount        (in_amount),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_seg_valid    (out_seg_valid),
    .out_seg_value    (out_seg_value),
    .out_seg_is_taint (out_seg_is_taint),
    .out_last         (out_last),
    .out_taint_total  (out_taint_total),
    .out_grand_total  (out_grand_total),
    .out_has_taint    (out_has_taint)
  );

  trlf_run_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_amount        (in_amount),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_seg_valid    (out_seg_valid),
    .out_seg_value    (out_seg_value),
    .out_seg_is_taint (out_seg_is_taint),
    .out_last         (out_last),
    .out_taint_total  (out_taint_total),
    .out_grand_total  (out_grand_total),
    .out_has_taint    (out_has_taint),
    .fail_count       (fail_count),
    .pending          (pending),
    .stored_total     (stored_total)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side back-pressure in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // present one item, with an occasional gap first, and wait until taken
  task automatic send_item(trlf_pkg::op_t op, logic [AMT_W-1:0] amt);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_amount    <= amt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending until every predicted result has come out
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [AMT_W-1:0] pick_amount(bit nonzero);
    logic [AMT_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = AMT_MAX;
      2, 3:    v = AMT_W'({$urandom, $urandom});
      default: v = AMT_W'($urandom_range(1, 20));
    endcase
    if (nonzero && v == '0) v = AMT_W'(1);
    return v;
  endfunction

  // assign amounts around the stored total: exact, just over, inside, wild
  function automatic logic [AMT_W-1:0] pick_assign(logic [SUM_W-1:0] tot);
    logic [SUM_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = tot;
      1:       v = tot + SUM_W'(1);
      2:       v = '0;
      3:       v = {$urandom, $urandom};
      default: v = (tot == '1) ? tot : {$urandom, $urandom} % (tot + SUM_W'(1));
    endcase
    if (v > SUM_W'(AMT_MAX)) v = SUM_W'(AMT_MAX);
    return AMT_W'(v);
  endfunction

  initial begin
    int            n_rand;
    trlf_pkg::op_t op;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty ring, merge rules, splits, over-amounts, extremes
    send_item(trlf_pkg::OP_QUERY, '0);
    send_item(trlf_pkg::OP_ASSIGN, '0);
    send_item(trlf_pkg::OP_ASSIGN, AMT_W'(1));
    send_item(trlf_pkg::OP_ADD_TAINT, AMT_W'(5));
    send_item(trlf_pkg::OP_ADD_CLEAN, '0);
    send_item(trlf_pkg::OP_ADD_TAINT, AMT_W'(7));
    send_item(trlf_pkg::OP_ADD_CLEAN, AMT_W'(3));
    send_item(trlf_pkg::OP_ADD_TAINT, '0);
    send_item(trlf_pkg::OP_ADD_CLEAN, AMT_W'(4));
    send_item(trlf_pkg::OP_QUERY, AMT_MAX);
    send_item(trlf_pkg::OP_ASSIGN, AMT_W'(2));
    send_item(trlf_pkg::OP_ASSIGN, '0);
    send_item(trlf_pkg::OP_ADD_TAINT, AMT_W'(1));
    send_item(trlf_pkg::OP_ADD_CLEAN, AMT_W'(2));
    // take all five runs: ring left with one zero clean run
    hold_until_drained();
    send_item(trlf_pkg::OP_ASSIGN, AMT_W'(stored_total));
    send_item(trlf_pkg::OP_ADD_CLEAN, AMT_MAX);
    send_item(trlf_pkg::OP_ADD_TAINT, AMT_MAX);
    send_item(trlf_pkg::OP_ASSIGN, AMT_MAX);
    send_item(trlf_pkg::OP_ASSIGN, AMT_MAX);
    send_item(trlf_pkg::OP_QUERY, '0);
    hold_until_drained();
    send_item(trlf_pkg::OP_ASSIGN, AMT_MAX);
    send_item(trlf_pkg::OP_QUERY, AMT_MAX);

    // random: fill bursts up to a full ring, drains and mixed items
    n_rand = 0;
    while (n_rand < N_RANDOM) begin
      calm <= (n_rand >= N_RANDOM - N_CALM);
      case ((n_rand == 0) ? 0 : $urandom_range(0, 9))
        0: begin
          // alternating nonzero adds fill the ring, sent past the ring size
          for (int i = 0; i < FILL_LEN; i++) begin
            send_item((i % 2 == 1) ? trlf_pkg::OP_ADD_TAINT : trlf_pkg::OP_ADD_CLEAN,
                      ($urandom_range(0, 7) == 0) ? pick_amount(1'b1)
                                                  : AMT_W'($urandom_range(1, 20)));
          end
          n_rand += FILL_LEN;
          if (!calm) hold_until_drained();
          send_item(trlf_pkg::OP_ASSIGN, pick_assign(stored_total));
          n_rand++;
        end
        1, 2: begin
          if (!calm && $urandom_range(0, 1) == 1) hold_until_drained();
          send_item(trlf_pkg::OP_ASSIGN, pick_assign(stored_total));
          n_rand++;
        end
        default: begin
          op = trlf_pkg::op_t'($urandom_range(0, 3));
          send_item(op, (op == trlf_pkg::OP_ASSIGN) ? pick_assign(stored_total)
                                                    : pick_amount(1'b0));
          n_rand++;
        end
      endcase
    end

    // let every result out, then a quiet tail
    hold_until_drained();
    repeat (TAIL) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/trlf_pkg.sv
rtl/trlf_ctrl.sv
rtl/trlf_dp.sv
rtl/taint_run_length_fifo.sv
verif/trlf_run_checker.sv
verif/taint_run_length_fifo_tb.sv
